FILE: rtl/ring_buffer_deque_core_assert.svh
// assertion macros for the ring buffer deque core
// included by the top level, no other dependencies
`ifndef RING_BUFFER_DEQUE_CORE_ASSERT_SVH
`define RING_BUFFER_DEQUE_CORE_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define RBD_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("ring buffer deque assertion failed");

// next-cycle implication under synchronous active-low reset
`define RBD_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("ring buffer deque assertion failed");

`endif

FILE: rtl/rbd_pkg.sv
// shared types and constants for the ring buffer deque core
// no dependencies
`timescale 1ns / 1ps

package rbd_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = 7;
    localparam int WORD_W = 32;
    localparam int REQ_W = 3;
    localparam int STAT_W = 2;
    localparam int IN_W = 40;
    localparam int OUT_W = 80;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUERY = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic load_req;
        logic exec;
        logic rd;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic signed [WORD_W-1:0] back_word;
        logic signed [WORD_W-1:0] front_word;
        logic values_valid;
        logic is_empty;
        logic [CNT_W-1:0] count;
        logic [STAT_W-1:0] status;
    } t_result;

endpackage

FILE: rtl/rbd_ctrl.sv
// request sequencer for the ring buffer deque core
// depends on rbd_pkg
`timescale 1ns / 1ps

module rbd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output rbd_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_load_out;

    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_READ;
            S_READ: n_state = S_DONE;
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready     = (r_state == S_IDLE);
    assign o_m_tvalid     = r_out_valid;
    assign o_cmd.load_req = (r_state == S_IDLE) && i_s_tvalid;
    assign o_cmd.exec     = (r_state == S_EXEC);
    assign o_cmd.rd       = (r_state == S_READ);
    assign o_cmd.load_out = w_load_out;

endmodule

FILE: rtl/rbd_dpath.sv
// indices, count, word store and result register of the ring buffer deque core
// depends on rbd_pkg
`timescale 1ns / 1ps

module rbd_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rbd_pkg::t_cmd                       i_cmd,
    input  logic [rbd_pkg::REQ_W-1:0]           i_req_type,
    input  logic signed [rbd_pkg::WORD_W-1:0]   i_push_value,
    output rbd_pkg::t_result                    o_result
);

    logic [rbd_pkg::WORD_W-1:0] r_mem [rbd_pkg::DEPTH];

    logic [rbd_pkg::REQ_W-1:0]  r_req;
    logic [rbd_pkg::WORD_W-1:0] r_word;
    logic [rbd_pkg::IDX_W-1:0]  r_head, n_head;
    logic [rbd_pkg::IDX_W-1:0]  r_tail, n_tail;
    logic [rbd_pkg::CNT_W-1:0]  r_count, n_count;
    logic [rbd_pkg::STAT_W-1:0] r_status, n_status;
    logic [rbd_pkg::WORD_W-1:0] r_rd_front, r_rd_back;
    rbd_pkg::t_result           r_result;

    logic                       w_full, w_empty;
    logic [rbd_pkg::IDX_W-1:0]  w_head_up, w_head_dn, w_tail_up, w_tail_dn;
    logic                       w_wr_en;
    logic [rbd_pkg::IDX_W-1:0]  w_wr_addr;

    localparam logic [rbd_pkg::IDX_W-1:0] IDX_LAST = rbd_pkg::IDX_W'(rbd_pkg::DEPTH - 1);

    assign w_full  = (r_count == rbd_pkg::CNT_W'(rbd_pkg::DEPTH));
    assign w_empty = (r_count == '0);

    assign w_head_up = (r_head == IDX_LAST) ? '0 : r_head + 1'b1;
    assign w_head_dn = (r_head == '0) ? IDX_LAST : r_head - 1'b1;
    assign w_tail_up = (r_tail == IDX_LAST) ? '0 : r_tail + 1'b1;
    assign w_tail_dn = (r_tail == '0) ? IDX_LAST : r_tail - 1'b1;

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_status  = rbd_pkg::ST_DONE;
        w_wr_en   = 1'b0;
        w_wr_addr = r_tail;
        case (r_req)
            rbd_pkg::REQ_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = rbd_pkg::ST_FULL;
                end else begin
                    n_head    = w_head_dn;
                    n_count   = r_count + 1'b1;
                    w_wr_en   = 1'b1;
                    w_wr_addr = w_head_dn;
                end
            end
            rbd_pkg::REQ_PUSH_BACK: begin
                if (w_full) begin
                    n_status = rbd_pkg::ST_FULL;
                end else begin
                    n_tail    = w_tail_up;
                    n_count   = r_count + 1'b1;
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_tail;
                end
            end
            rbd_pkg::REQ_POP_FRONT: begin
                if (w_empty) begin
                    n_status = rbd_pkg::ST_EMPTY;
                end else begin
                    n_head  = w_head_up;
                    n_count = r_count - 1'b1;
                end
            end
            rbd_pkg::REQ_POP_BACK: begin
                if (w_empty) begin
                    n_status = rbd_pkg::ST_EMPTY;
                end else begin
                    n_tail  = w_tail_dn;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req  <= i_req_type;
            r_word <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
    end

    // store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_wr_en) begin
            r_mem[w_wr_addr] <= r_word;
        end
        if (i_cmd.rd) begin
            r_rd_front <= r_mem[r_head];
            r_rd_back  <= r_mem[w_tail_dn];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_result.status       <= r_status;
            r_result.count        <= r_count;
            r_result.is_empty     <= w_empty;
            r_result.values_valid <= !w_empty;
            r_result.front_word   <= w_empty ? '0 : r_rd_front;
            r_result.back_word    <= w_empty ? '0 : r_rd_back;
        end
    end

    assign o_result = r_result;

endmodule

FILE: rtl/ring_buffer_deque_core.sv
// top level of the ring buffer deque core: sequencer plus datapath
// depends on rbd_pkg, rbd_ctrl, rbd_dpath and ring_buffer_deque_core_assert.svh
//
//  channel   direction  width  fields (low bit up)
//  s_axis    in         40     req_type[2:0], push_value[34:3], zero fill
//  m_axis    out        80     status[1:0], count[8:2], is_empty[9],
//                              values_valid[10], front_word[42:11],
//                              back_word[74:43], zero fill
//
// one request in flight: accept, index update and store write, registered
// store read, result load; the result is valid once it is loaded, and a
// new request is taken only after the result load
// the result register lets the next request be taken while a result waits
// a stalled result side holds the sequencer in its last step
// synchronous reset clears indices and count; the store is not cleared
`timescale 1ns / 1ps

`include "ring_buffer_deque_core_assert.svh"

module ring_buffer_deque_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // req_type[2:0], push_value[34:3]
    input  logic [rbd_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // status[1:0], count[8:2], is_empty[9], values_valid[10],
    // front_word[42:11], back_word[74:43]
    output logic [rbd_pkg::OUT_W-1:0]   o_m_axis_tdata
);

    rbd_pkg::t_cmd    w_cmd;
    rbd_pkg::t_result w_result;

    rbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_cmd      (w_cmd)
    );

    rbd_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_req_type   (i_s_axis_tdata[rbd_pkg::REQ_W-1:0]),
        .i_push_value (i_s_axis_tdata[rbd_pkg::REQ_W +: rbd_pkg::WORD_W]),
        .o_result     (w_result)
    );

    assign o_m_axis_tdata = {(rbd_pkg::OUT_W - $bits(rbd_pkg::t_result))'(0), w_result};

    `RBD_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    `RBD_ASSERT_NEXT(a_exec_then_read, i_clk, i_rst_n, w_cmd.exec, w_cmd.rd)
    `RBD_ASSERT_NEXT(a_load_shows_result, i_clk, i_rst_n, w_cmd.load_out, o_m_axis_tvalid)
    `RBD_ASSERT_SAME(a_empty_flag_matches, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[9] == (o_m_axis_tdata[8:2] == '0))

endmodule

FILE: tb/rbd_result_checker.sv
// checker for the ring buffer deque core: watches both stream channels,
// tracks the deque contents on its own and compares every result transfer
// depends on rbd_pkg
`timescale 1ns / 1ps

module rbd_result_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    input  logic                        i_s_axis_tready,
    // req_type[2:0], push_value[34:3]
    input  logic [rbd_pkg::IN_W-1:0]    i_s_axis_tdata,
    input  logic                        i_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // status[1:0], count[8:2], is_empty[9], values_valid[10],
    // front_word[42:11], back_word[74:43]
    input  logic [rbd_pkg::OUT_W-1:0]   i_m_axis_tdata,
    output int                          o_fail_count,
    output int                          o_pending
);

    import rbd_pkg::*;

    logic signed [WORD_W-1:0] deque_words [DEPTH];
    logic [IDX_W-1:0]         front_idx;
    logic [IDX_W-1:0]         back_end_idx;
    logic [CNT_W-1:0]         live_count;
    t_result                  pending_results [$];

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        front_idx = '0;
        back_end_idx = '0;
        live_count = '0;
    end

    function automatic logic [IDX_W-1:0] idx_up(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_down(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - 1'b1;
    endfunction

    task automatic apply_request(input logic [REQ_W-1:0] req,
                                 input logic signed [WORD_W-1:0] word,
                                 output t_result res);
        res = '0;
        res.status = ST_DONE;
        case (req)
            REQ_PUSH_FRONT: begin
                if (live_count >= CNT_W'(DEPTH)) begin
                    res.status = ST_FULL;
                end else begin
                    front_idx = idx_down(front_idx);
                    deque_words[front_idx] = word;
                    live_count = live_count + 1'b1;
                end
            end
            REQ_PUSH_BACK: begin
                if (live_count >= CNT_W'(DEPTH)) begin
                    res.status = ST_FULL;
                end else begin
                    deque_words[back_end_idx] = word;
                    back_end_idx = idx_up(back_end_idx);
                    live_count = live_count + 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                if (live_count == '0) begin
                    res.status = ST_EMPTY;
                end else begin
                    front_idx = idx_up(front_idx);
                    live_count = live_count - 1'b1;
                end
            end
            REQ_POP_BACK: begin
                if (live_count == '0) begin
                    res.status = ST_EMPTY;
                end else begin
                    back_end_idx = idx_down(back_end_idx);
                    live_count = live_count - 1'b1;
                end
            end
            // query and the unused codes leave the deque alone
            default: begin
            end
        endcase
        res.count = live_count;
        res.is_empty = (live_count == '0);
        res.values_valid = (live_count != '0);
        if (res.values_valid) begin
            res.front_word = deque_words[front_idx];
            res.back_word = deque_words[idx_down(back_end_idx)];
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want_r;
        t_result got_r;
        if (!i_rst_n) begin
            front_idx = '0;
            back_end_idx = '0;
            live_count = '0;
            pending_results.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                apply_request(i_s_axis_tdata[REQ_W-1:0],
                              i_s_axis_tdata[REQ_W +: WORD_W], want_r);
                pending_results.push_back(want_r);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got_r = t_result'(i_m_axis_tdata[$bits(t_result)-1:0]);
                if (pending_results.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    o_fail_count++;
                end else begin
                    want_r = pending_results.pop_front();
                    check_field("status", want_r.status, got_r.status);
                    check_field("count", want_r.count, got_r.count);
                    check_field("is_empty", want_r.is_empty, got_r.is_empty);
                    check_field("values_valid", want_r.values_valid, got_r.values_valid);
                    check_field("front_word", want_r.front_word, got_r.front_word);
                    check_field("back_word", want_r.back_word, got_r.back_word);
                end
            end
        end
        o_pending = pending_results.size();
    end

endmodule

FILE: tb/testbench.sv
// top of the ring buffer deque testbench: clock, reset, request stimulus
// and result-side stalls; depends on rbd_pkg, ring_buffer_deque_core and
// rbd_result_checker
`timescale 1ns / 1ps

module testbench;

    import rbd_pkg::*;

    localparam int RANDOM_REQS = 700;

    logic             clk;
    logic             rst_n;
    logic             s_valid;
    logic             s_ready;
    logic [IN_W-1:0]  s_data;
    logic             m_valid;
    logic             m_ready;
    logic [OUT_W-1:0] m_data;
    int               fail_count;
    int               pending;
    bit               tx_fast;
    bit               rx_fast;

    ring_buffer_deque_core i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    rbd_result_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic [WORD_W-1:0] word);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data <= {{(IN_W - REQ_W - WORD_W){1'b0}}, word, req};
        do @(posedge clk); while (!s_ready);
        @(negedge clk);
    endtask

    function automatic logic [REQ_W-1:0] pick_push();
        return $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    endfunction

    function automatic logic [REQ_W-1:0] pick_pop();
        return $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
    endfunction

    // query or one of the unused codes above it
    function automatic logic [REQ_W-1:0] pick_other();
        return REQ_W'($urandom_range(int'(REQ_QUERY), (1 << REQ_W) - 1));
    endfunction

    // result side: a fresh stall before every transfer, with quiet stretches
    initial begin
        m_ready = 1'b0;
        rx_fast = 1'b0;
        @(negedge clk);
        wait (rst_n);
        forever begin
            int stall;
            if ($urandom_range(0, 39) == 0) begin
                rx_fast = !rx_fast;
            end
            stall = rx_fast ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_ready <= 1'b1;
            do @(posedge clk); while (!m_valid);
            @(negedge clk);
        end
    end

    initial begin
        int bias;
        int phase_len;
        int roll;
        int sent;
        logic [REQ_W-1:0] req;

        rst_n = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        tx_fast = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty-queue rejects, unused codes, extreme words, drain back to empty
        send_request(REQ_QUERY, 32'h0);
        send_request(REQ_POP_FRONT, 32'hFFFF_FFFF);
        send_request(REQ_POP_BACK, 32'h1234_5678);
        send_request(REQ_W'(5), 32'hDEAD_BEEF);
        send_request(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
        send_request(REQ_PUSH_BACK, 32'h8000_0000);
        send_request(REQ_QUERY, 32'hFFFF_FFFF);
        send_request(REQ_W'(6), 32'h0);
        send_request(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(REQ_PUSH_BACK, 32'h0000_0000);
        send_request(REQ_PUSH_FRONT, 32'hAAAA_AAAA);
        send_request(REQ_PUSH_BACK, 32'h5555_5555);
        send_request(REQ_POP_BACK, 32'h0);
        send_request(REQ_POP_FRONT, 32'h0);
        send_request(REQ_W'(7), 32'hFFFF_FFFF);
        send_request(REQ_POP_FRONT, 32'h0);
        send_request(REQ_POP_BACK, 32'h0);
        send_request(REQ_POP_BACK, 32'h0);
        send_request(REQ_POP_FRONT, 32'h0);
        send_request(REQ_POP_BACK, 32'h0);
        send_request(REQ_POP_FRONT, 32'h0);

        // phases that fill to full, drain to empty, or wander in between
        sent = 0;
        while (sent < RANDOM_REQS) begin
            phase_len = $urandom_range(40, 120);
            bias = $urandom_range(0, 2);
            tx_fast = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < phase_len && sent < RANDOM_REQS; n++) begin
                roll = $urandom_range(0, 99);
                case (bias)
                    0: req = (roll < 85) ? pick_push() : (roll < 97) ? pick_pop() : pick_other();
                    1: req = (roll < 85) ? pick_pop() : (roll < 97) ? pick_push() : pick_other();
                    default: req = (roll < 40) ? pick_push() : (roll < 80) ? pick_pop()
                                                                          : pick_other();
                endcase
                send_request(req, $urandom());
                sent++;
            end
        end
        s_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: ring_buffer_deque_core.f
+incdir+rtl
rtl/rbd_pkg.sv
rtl/rbd_ctrl.sv
rtl/rbd_dpath.sv
rtl/ring_buffer_deque_core.sv
tb/rbd_result_checker.sv
tb/testbench.sv
